[rtl/intel_hex_record_loader_defines.svh]
// Assertion macros for the loader's decoder module.
`ifndef INTEL_HEX_RECORD_LOADER_DEFINES_SVH
`define INTEL_HEX_RECORD_LOADER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IHEX_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ihex: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IHEX_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ihex: next-cycle check failed");

`endif

[rtl/ihex_pkg.sv]
// Types and codes shared by the Intel HEX loader modules.
`default_nettype none

package ihex_pkg;

    // Fixed field widths
    localparam int ADDR_W = 19;
    localparam int LINE_W = 16;

    // Characters of the record syntax
    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] CR_CHAR    = 8'h0D;

    // Record types
    localparam logic [7:0] TYPE_DATA    = 8'h00;
    localparam logic [7:0] TYPE_END     = 8'h01;
    localparam logic [7:0] TYPE_SEGMENT = 8'h04;

    // Run status codes
    localparam logic [1:0] RUN_PARSING = 2'd0;
    localparam logic [1:0] RUN_DONE    = 2'd1;
    localparam logic [1:0] RUN_ERROR   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_COLON   = 3'd1;
    localparam logic [2:0] ERR_CR      = 3'd2;
    localparam logic [2:0] ERR_LENGTH  = 3'd3;
    localparam logic [2:0] ERR_SEGMENT = 3'd4;
    localparam logic [2:0] ERR_CHECK   = 3'd5;
    localparam logic [2:0] ERR_DIGIT   = 3'd6;

    // One result per character
    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_byte;
        logic [1:0]        run_status;
        logic [2:0]        error_kind;
        logic [LINE_W-1:0] lines_done;
    } result_t;

endpackage

`default_nettype wire

[rtl/intel_hex_record_loader.sv]
// A character request is taken into the input register; its result is registered in res_reg.
// Throughput: one character per cycle while unstalled; parse state updates in a single pass.
// A stalled result holds the pipe; the input register then raises char_stall.
// Reset (rst_n, asynchronous, active low) empties both registers and returns
// the parser to colon search with no error and a zero line count.
`default_nettype none

module intel_hex_record_loader #(
    parameter int IMAGE_BYTES    = 262144,
    parameter int SEARCH_LIMIT   = 128,
    parameter int MAX_DATA_BYTES = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          char_valid,
    output wire logic                          char_stall,
    input  wire logic [7:0]                    char_in,
    output wire logic                          result_valid,
    input  wire logic                          result_stall,
    output wire logic                          write_valid,
    output wire logic [ihex_pkg::ADDR_W-1:0]   write_address,
    output wire logic [7:0]                    write_byte,
    output wire logic [1:0]                    run_status,
    output wire logic [2:0]                    error_kind,
    output wire logic [ihex_pkg::LINE_W-1:0]   lines_done
);

    logic              char_valid_reg;
    logic [7:0]        char_reg;
    logic              res_valid_reg;
    ihex_pkg::result_t res_reg;
    ihex_pkg::result_t step_result;
    logic              out_free;
    logic              step;

    // Pipe control
    assign out_free   = !res_valid_reg || !result_stall;
    assign step       = char_valid_reg && out_free;
    assign char_stall = char_valid_reg && !out_free;

    ihex_decoder #(
        .IMAGE_BYTES    (IMAGE_BYTES),
        .SEARCH_LIMIT   (SEARCH_LIMIT),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (char_reg),
        .result  (step_result)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!char_stall)
            begin
                char_valid_reg <= char_valid;
            end
            if (out_free)
            begin
                res_valid_reg <= step;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            char_reg <= char_in;
        end
        if (step)
        begin
            res_reg <= step_result;
        end
    end

    assign result_valid  = res_valid_reg;
    assign write_valid   = res_reg.write_valid;
    assign write_address = res_reg.write_address;
    assign write_byte    = res_reg.write_byte;
    assign run_status    = res_reg.run_status;
    assign error_kind    = res_reg.error_kind;
    assign lines_done    = res_reg.lines_done;

endmodule

`default_nettype wire

[rtl/ihex_decoder.sv]
// Record parser: parse state and the per-character update.
`default_nettype none
`include "intel_hex_record_loader_defines.svh"

module ihex_decoder #(
    parameter int IMAGE_BYTES    = 262144,
    parameter int SEARCH_LIMIT   = 128,
    parameter int MAX_DATA_BYTES = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       char_in,
    output ihex_pkg::result_t     result
);

    localparam int CNT_W   = $clog2(SEARCH_LIMIT + 1);
    localparam int LEN_W   = $clog2(MAX_DATA_BYTES + 1);
    localparam int NEED_W  = $clog2(2 * (5 + MAX_DATA_BYTES) + 1);
    localparam int CMP_W   = (CNT_W > NEED_W) ? CNT_W : NEED_W;
    localparam int SEG_MAX = IMAGE_BYTES / 65536 - 1;
    localparam int SEG_W   = (SEG_MAX > 0) ? $clog2(SEG_MAX + 1) : 1;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_RECORD,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            fpos_reg, fpos_next;
    logic [3:0]                  nibble_reg, nibble_next;
    logic [7:0]                  check_reg, check_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [15:0]                 raddr_reg, raddr_next;
    logic [7:0]                  rtype_reg, rtype_next;
    logic [SEG_W-1:0]            seg_reg, seg_next;
    logic [7:0]                  seg_high_reg, seg_high_next;
    logic [ihex_pkg::LINE_W-1:0] line_reg, line_next;
    logic [2:0]                  err_reg, err_next;

    // Hex digit decode
    logic       hex_ok;
    logic [3:0] hex_val;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (char_in >= 8'h30 && char_in <= 8'h39)
        begin
            hex_val = 4'(char_in - 8'h30);
        end
        else if (char_in >= 8'h41 && char_in <= 8'h46)
        begin
            hex_val = 4'(char_in - 8'h37);
        end
        else if (char_in >= 8'h61 && char_in <= 8'h66)
        begin
            hex_val = 4'(char_in - 8'h57);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    // Record bookkeeping terms
    logic [CMP_W-1:0]          needed;
    logic [CMP_W-1:0]          fpos_ext;
    logic [CMP_W-1:0]          idx;
    logic                      complete;
    logic [CNT_W-1:0]          count_inc;
    logic [7:0]                byte_val;
    logic [LEN_W-1:0]          data_k;
    logic [15:0]               seg_value;
    logic [ihex_pkg::ADDR_W-1:0] wr_addr;

    assign needed    = (CMP_W'(len_reg) + CMP_W'(5)) << 1;
    assign fpos_ext  = CMP_W'(fpos_reg);
    assign idx       = fpos_ext >> 1;
    assign complete  = (fpos_ext >= CMP_W'(10)) && (fpos_ext >= needed);
    assign count_inc = count_reg + CNT_W'(1);
    assign byte_val  = {nibble_reg, hex_val};
    assign data_k    = LEN_W'(idx - CMP_W'(4));
    assign seg_value = {seg_high_reg, byte_val};
    assign wr_addr   = (ihex_pkg::ADDR_W'(seg_reg) << 16) + ihex_pkg::ADDR_W'(raddr_reg)
                     + ihex_pkg::ADDR_W'(data_k);

    // Next state and result for one character
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        fpos_next     = fpos_reg;
        nibble_next   = nibble_reg;
        check_next    = check_reg;
        len_next      = len_reg;
        raddr_next    = raddr_reg;
        rtype_next    = rtype_reg;
        seg_next      = seg_reg;
        seg_high_next = seg_high_reg;
        line_next     = line_reg;
        err_next      = err_reg;

        result.write_valid   = 1'b0;
        result.write_address = '0;
        result.write_byte    = '0;

        if (step)
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (char_in == ihex_pkg::COLON_CHAR)
                    begin
                        phase_next    = PH_RECORD;
                        count_next    = '0;
                        fpos_next     = '0;
                        nibble_next   = '0;
                        check_next    = '0;
                        len_next      = '0;
                        raddr_next    = '0;
                        rtype_next    = '0;
                        seg_high_next = '0;
                        if (line_reg != '1)
                        begin
                            line_next = line_reg + ihex_pkg::LINE_W'(1);
                        end
                    end
                    else
                    begin
                        count_next = count_inc;
                        if (count_inc >= CNT_W'(SEARCH_LIMIT))
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ihex_pkg::ERR_COLON;
                        end
                    end
                end
                PH_RECORD:
                begin
                    count_next = count_inc;
                    if (char_in == ihex_pkg::CR_CHAR)
                    begin
                        if (!complete)
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ihex_pkg::ERR_DIGIT;
                        end
                        else if (len_reg == '0 && rtype_reg == ihex_pkg::TYPE_END
                                 && raddr_reg == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_SEARCH;
                            count_next = '0;
                        end
                    end
                    else if (count_inc >= CNT_W'(SEARCH_LIMIT) || complete)
                    begin
                        phase_next = PH_ERROR;
                        err_next   = ihex_pkg::ERR_CR;
                    end
                    else if (!hex_ok)
                    begin
                        phase_next = PH_ERROR;
                        err_next   = ihex_pkg::ERR_DIGIT;
                    end
                    else if (!fpos_reg[0])
                    begin
                        // high digit of a byte
                        nibble_next = hex_val;
                        fpos_next   = fpos_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // low digit completes a byte
                        fpos_next  = fpos_reg + CNT_W'(1);
                        check_next = check_reg + byte_val;
                        if (idx == CMP_W'(0))
                        begin
                            len_next = LEN_W'(byte_val);
                            if (byte_val > 8'(MAX_DATA_BYTES))
                            begin
                                phase_next = PH_ERROR;
                                err_next   = ihex_pkg::ERR_LENGTH;
                            end
                        end
                        else if (idx == CMP_W'(1))
                        begin
                            raddr_next = {byte_val, 8'h00};
                        end
                        else if (idx == CMP_W'(2))
                        begin
                            raddr_next = {raddr_reg[15:8], byte_val};
                        end
                        else if (idx == CMP_W'(3))
                        begin
                            rtype_next = byte_val;
                        end
                        else if (idx < CMP_W'(len_reg) + CMP_W'(4))
                        begin
                            if (rtype_reg == ihex_pkg::TYPE_DATA)
                            begin
                                result.write_valid   = 1'b1;
                                result.write_address = wr_addr;
                                result.write_byte    = byte_val;
                            end
                            else if (rtype_reg == ihex_pkg::TYPE_SEGMENT
                                     && len_reg == LEN_W'(2))
                            begin
                                if (data_k == '0)
                                begin
                                    seg_high_next = byte_val;
                                end
                                else if (seg_value > 16'(SEG_MAX))
                                begin
                                    phase_next = PH_ERROR;
                                    err_next   = ihex_pkg::ERR_SEGMENT;
                                end
                                else
                                begin
                                    seg_next = SEG_W'(seg_value);
                                end
                            end
                        end
                        else if (check_reg + byte_val != 8'h00)
                        begin
                            // checksum byte leaves a nonzero sum
                            phase_next = PH_ERROR;
                            err_next   = ihex_pkg::ERR_CHECK;
                        end
                    end
                end
                PH_DONE, PH_ERROR:
                begin
                end
                default:
                begin
                end
            endcase
        end

        unique case (phase_next)
            PH_DONE:  result.run_status = ihex_pkg::RUN_DONE;
            PH_ERROR: result.run_status = ihex_pkg::RUN_ERROR;
            default:  result.run_status = ihex_pkg::RUN_PARSING;
        endcase
        result.error_kind = err_next;
        result.lines_done = line_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEARCH;
            count_reg    <= '0;
            fpos_reg     <= '0;
            nibble_reg   <= '0;
            check_reg    <= '0;
            len_reg      <= '0;
            raddr_reg    <= '0;
            rtype_reg    <= '0;
            seg_reg      <= '0;
            seg_high_reg <= '0;
            line_reg     <= '0;
            err_reg      <= ihex_pkg::ERR_NONE;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            fpos_reg     <= fpos_next;
            nibble_reg   <= nibble_next;
            check_reg    <= check_next;
            len_reg      <= len_next;
            raddr_reg    <= raddr_next;
            rtype_reg    <= rtype_next;
            seg_reg      <= seg_next;
            seg_high_reg <= seg_high_next;
            line_reg     <= line_next;
            err_reg      <= err_next;
        end
    end

    // Checks
    `IHEX_ASSERT_NEXT(a_error_sticky, clk, rst_n, phase_reg == PH_ERROR, phase_reg == PH_ERROR && $stable(err_reg))
    `IHEX_ASSERT_IMPLIES(a_error_code, clk, rst_n, 1'b1, (err_reg != ihex_pkg::ERR_NONE) == (phase_reg == PH_ERROR))
    `IHEX_ASSERT_IMPLIES(a_write_in_record, clk, rst_n, result.write_valid, step && phase_reg == PH_RECORD && rtype_reg == ihex_pkg::TYPE_DATA)
    `IHEX_ASSERT_IMPLIES(a_count_limit, clk, rst_n, phase_reg == PH_SEARCH || phase_reg == PH_RECORD, count_reg < CNT_W'(SEARCH_LIMIT))

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the Intel HEX record loader: character stream in, one result out.
`timescale 1ns / 100ps

module testbench;

    localparam int IMAGE_BYTES    = 262144;
    localparam int SEARCH_LIMIT   = 128;
    localparam int MAX_DATA_BYTES = 32;
    localparam int SEGMENT_MAX    = (IMAGE_BYTES - 65536) / 65536;
    localparam int RANDOM_CHARS   = 1900;
    localparam int TAIL_CHARS     = 150;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 80;
    localparam int QUIET_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_F = "F";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_F = "f";
    localparam logic [7:0] CH_LF      = 8'h0A;

    typedef enum logic [1:0] {SEEK_COLON, IN_RECORD, LOADED, HALTED} parse_phase_t;

    // How the stream is brought to its end; errors are sticky and reset is applied once,
    // so each run closes on one of these, chosen at random
    typedef enum int {
        END_OK, END_NO_COLON, END_TRAILING, END_SHORT,
        END_BAD_DIGIT, END_LONG, END_SEGMENT, END_CHECKSUM
    } stream_end_t;

    typedef struct {
        logic [7:0] ch;
        bit         hold_for_drain;
    } feed_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic char_valid = 1'b0;
    logic [7:0] char_in = 8'h00;
    logic result_stall = 1'b0;
    logic char_stall;
    logic result_valid;
    logic write_valid;
    logic [ihex_pkg::ADDR_W-1:0] write_address;
    logic [7:0] write_byte;
    logic [1:0] run_status;
    logic [2:0] error_kind;
    logic [ihex_pkg::LINE_W-1:0] lines_done;

    // Stimulus and scoreboard
    feed_item_t        char_feed[$];
    logic [7:0]        line_buf[$];
    ihex_pkg::result_t char_results_due[$];
    bit                drain_next = 1'b0;
    bit                feed_done = 1'b0;
    bit                calm_tail = 1'b0;
    int                chars_sent = 0;
    int                results_seen = 0;
    int                mismatches = 0;
    int                quiet_cycles = 0;

    // Idling state, one set per side
    int send_gap = 0;
    int send_cyc = 0;
    int send_pct = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int recv_cyc = 0;
    int recv_pct = 0;

    // Loader state as the predictor sees it
    parse_phase_t loader_phase = SEEK_COLON;
    logic [7:0]   rec_chars = 8'h00;
    logic [7:0]   digits_taken = 8'h00;
    logic [3:0]   nibble_held = 4'h0;
    logic [7:0]   sum_so_far = 8'h00;
    logic [7:0]   rec_len = 8'h00;
    logic [15:0]  rec_addr = 16'h0000;
    logic [7:0]   rec_type = 8'h00;
    logic [7:0]   rec_segment = 8'h00;
    logic [7:0]   seg_high = 8'h00;
    logic [15:0]  lines_seen = 16'h0000;
    logic [2:0]   err_code = ihex_pkg::ERR_NONE;

    intel_hex_record_loader #(
        .IMAGE_BYTES    (IMAGE_BYTES),
        .SEARCH_LIMIT   (SEARCH_LIMIT),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_in       (char_in),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .write_valid   (write_valid),
        .write_address (write_address),
        .write_byte    (write_byte),
        .run_status    (run_status),
        .error_kind    (error_kind),
        .lines_done    (lines_done)
    );

    always #5 clk = ~clk;

    // {is hex digit, value}
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = c - CH_ZERO;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            d = c - CH_UPPER_A + 8'd10;
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            d = c - CH_LOWER_A + 8'd10;
        else
            return 5'h00;
        return {1'b1, d[3:0]};
    endfunction

    function automatic void halt(logic [2:0] kind);
        loader_phase = HALTED;
        err_code = kind;
    endfunction

    // Advance the loader state by one character and give the result it produces
    function automatic ihex_pkg::result_t decode_char(logic [7:0] c);
        ihex_pkg::result_t r;
        logic [4:0]  hx;
        logic [7:0]  b;
        logic [15:0] seg_word;
        logic [31:0] addr_sum;
        int          idx;
        int          need;
        bit          complete;
        r = '0;
        case (loader_phase)
            SEEK_COLON:
            begin
                if (c == ihex_pkg::COLON_CHAR)
                begin
                    loader_phase = IN_RECORD;
                    rec_chars = 8'h00;
                    digits_taken = 8'h00;
                    nibble_held = 4'h0;
                    sum_so_far = 8'h00;
                    rec_len = 8'h00;
                    rec_addr = 16'h0000;
                    rec_type = 8'h00;
                    seg_high = 8'h00;
                    if (lines_seen != 16'hFFFF)
                        lines_seen++;
                end
                else
                begin
                    rec_chars++;
                    if (rec_chars >= SEARCH_LIMIT)
                        halt(ihex_pkg::ERR_COLON);
                end
            end
            IN_RECORD:
            begin
                need = 2 * (5 + rec_len);
                complete = digits_taken >= 10 && digits_taken >= need;
                rec_chars++;
                if (c == ihex_pkg::CR_CHAR)
                begin
                    if (!complete)
                        halt(ihex_pkg::ERR_DIGIT);
                    else if (rec_len == 0 && rec_type == ihex_pkg::TYPE_END && rec_addr == 0)
                        loader_phase = LOADED;
                    else
                    begin
                        loader_phase = SEEK_COLON;
                        rec_chars = 8'h00;
                    end
                end
                else if (rec_chars >= SEARCH_LIMIT || complete)
                    halt(ihex_pkg::ERR_CR);
                else
                begin
                    hx = hex_nibble(c);
                    if (!hx[4])
                        halt(ihex_pkg::ERR_DIGIT);
                    else if (!digits_taken[0])
                    begin
                        nibble_held = hx[3:0];
                        digits_taken++;
                    end
                    else
                    begin
                        // a whole byte is in: length, address, type, data or checksum
                        idx = digits_taken >> 1;
                        digits_taken++;
                        b = {nibble_held, hx[3:0]};
                        sum_so_far = sum_so_far + b;
                        if (idx == 0)
                        begin
                            rec_len = b;
                            if (b > MAX_DATA_BYTES)
                                halt(ihex_pkg::ERR_LENGTH);
                        end
                        else if (idx == 1)
                            rec_addr = {b, 8'h00};
                        else if (idx == 2)
                            rec_addr[7:0] = b;
                        else if (idx == 3)
                            rec_type = b;
                        else if (idx < 4 + rec_len)
                        begin
                            if (rec_type == ihex_pkg::TYPE_DATA)
                            begin
                                addr_sum = {rec_segment, 16'h0000} + rec_addr + (idx - 4);
                                r.write_valid = 1'b1;
                                r.write_address = addr_sum[ihex_pkg::ADDR_W-1:0];
                                r.write_byte = b;
                            end
                            else if (rec_type == ihex_pkg::TYPE_SEGMENT && rec_len == 2)
                            begin
                                if (idx == 4)
                                    seg_high = b;
                                else
                                begin
                                    seg_word = {seg_high, b};
                                    if ({seg_word, 16'h0000} > IMAGE_BYTES - 65536)
                                        halt(ihex_pkg::ERR_SEGMENT);
                                    else
                                        rec_segment = seg_word[7:0];
                                end
                            end
                        end
                        else if (sum_so_far != 8'h00)
                            halt(ihex_pkg::ERR_CHECK);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.run_status = (loader_phase == LOADED) ? ihex_pkg::RUN_DONE :
                       (loader_phase == HALTED) ? ihex_pkg::RUN_ERROR : ihex_pkg::RUN_PARSING;
        r.error_kind = err_code;
        r.lines_done = lines_seen;
        return r;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        c = $urandom_range(0, 255);
        if (c == ihex_pkg::COLON_CHAR)
            c = CH_LF;
        return c;
    endfunction

    function automatic logic [7:0] digit_char(logic [3:0] n);
        if (n < 10)
            return CH_ZERO + n;
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + (n - 10);
    endfunction

    task automatic send_char(logic [7:0] c);
        feed_item_t item;
        item.ch = c;
        item.hold_for_drain = drain_next;
        drain_next = 1'b0;
        char_feed.push_back(item);
    endtask

    task automatic put_byte(logic [7:0] b);
        line_buf.push_back(digit_char(b[7:4]));
        line_buf.push_back(digit_char(b[3:0]));
    endtask

    // Colon plus hex digits of one record into line_buf; skew spoils the checksum
    task automatic build_record(int len, logic [15:0] addr, logic [7:0] kind,
                                logic [15:0] seg_word, logic [7:0] skew);
        logic [7:0] sum;
        logic [7:0] b;
        int         n;
        line_buf.delete();
        line_buf.push_back(ihex_pkg::COLON_CHAR);
        sum = len[7:0] + addr[15:8] + addr[7:0] + kind;
        put_byte(len[7:0]);
        put_byte(addr[15:8]);
        put_byte(addr[7:0]);
        put_byte(kind);
        n = (len > MAX_DATA_BYTES) ? 2 : len;
        for (int i = 0; i < n; i++)
        begin
            if (kind == ihex_pkg::TYPE_SEGMENT && len == 2)
                b = (i == 0) ? seg_word[15:8] : seg_word[7:0];
            else
                b = $urandom_range(0, 255);
            sum = sum + b;
            put_byte(b);
        end
        put_byte(8'h00 - sum + skew);
    endtask

    task automatic flush_line(bit with_cr);
        foreach (line_buf[i])
            send_char(line_buf[i]);
        if (with_cr)
            send_char(ihex_pkg::CR_CHAR);
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s at result %0d: expected %0h, got %0h",
                         what, results_seen, want, got);
        end
    endtask

    // Character sender: predicts each accepted request, offers the next from the feed
    always @(posedge clk or negedge rst_n)
    begin : char_side
        feed_item_t item;
        bit         tail_now;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_in <= 8'h00;
            feed_done <= 1'b0;
            calm_tail <= 1'b0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                char_results_due.push_back(decode_char(char_in));
                chars_sent++;
            end
            send_cyc++;
            if (send_cyc % 128 == 0)
                send_pct = pick_pct();
            tail_now = char_feed.size() < TAIL_CHARS;
            calm_tail <= tail_now;
            // a stalled request stays on the bus unchanged
            if (!(char_valid && char_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    char_valid <= 1'b0;
                end
                else if (char_feed.size() == 0)
                begin
                    char_valid <= 1'b0;
                    feed_done <= 1'b1;
                end
                else if (char_feed[0].hold_for_drain && chars_sent != results_seen)
                    char_valid <= 1'b0;
                else if (!tail_now && $urandom_range(0, 99) < send_pct)
                begin
                    send_gap = $urandom_range(0, 7);
                    char_valid <= 1'b0;
                end
                else
                begin
                    item = char_feed.pop_front();
                    char_valid <= 1'b1;
                    char_in <= item.ch;
                end
            end
        end
    end

    // Result receiver: checks each accepted result, stalls in bursts and once at length
    always @(posedge clk or negedge rst_n)
    begin : result_side
        ihex_pkg::result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen <= results_seen + 1;
                if (char_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no character pending", results_seen);
                end
                else
                begin
                    want = char_results_due.pop_front();
                    check_field("write_valid", want.write_valid, write_valid);
                    check_field("write_address", want.write_address, write_address);
                    check_field("write_byte", want.write_byte, write_byte);
                    check_field("run_status", want.run_status, run_status);
                    check_field("error_kind", want.error_kind, error_kind);
                    check_field("lines_done", want.lines_done, lines_done);
                end
            end
            recv_cyc++;
            if (recv_cyc % 128 == 0)
                recv_pct = pick_pct();
            if (!hold_done && results_seen == HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 99) < recv_pct)
            begin
                stall_left = $urandom_range(0, 7);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog: cycles with no request taken on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((char_valid && !char_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles < QUIET_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : run_control
        int          len;
        int          pick;
        int          keep;
        int          pos;
        logic [7:0]  kind;
        logic [7:0]  c;
        logic [4:0]  hx;
        logic [15:0] addr;
        bit          drain_marked;
        stream_end_t ending;
        drain_marked = 1'b0;

        // Directed: extreme characters, top segment, top record address
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_LF);
        build_record(2, 16'h0000, ihex_pkg::TYPE_SEGMENT, SEGMENT_MAX, 8'h00);
        flush_line(1'b1);
        build_record(1, 16'hFFFF, ihex_pkg::TYPE_DATA, 16'h0000, 8'h00);
        flush_line(1'b1);

        // Random well-formed records with filler between them
        while (char_feed.size() < RANDOM_CHARS)
        begin
            if (!drain_marked && char_feed.size() > RANDOM_CHARS / 2)
            begin
                drain_next = 1'b1;
                drain_marked = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                send_char(ihex_pkg::CR_CHAR);
                send_char(CH_LF);
            end
            else if (pick < 60)
                repeat ($urandom_range(1, 4)) send_char(noise_char());
            else if (pick < 64)
                repeat ($urandom_range(5, SEARCH_LIMIT - 1)) send_char(noise_char());

            pick = $urandom_range(0, 99);
            addr = $urandom_range(0, 16'hFFFF);
            if (pick < 65)
            begin
                len = ($urandom_range(0, 9) == 0) ? MAX_DATA_BYTES
                                                  : $urandom_range(0, MAX_DATA_BYTES);
                build_record(len, addr, ihex_pkg::TYPE_DATA, 16'h0000, 8'h00);
            end
            else if (pick < 78)
                build_record(2, addr, ihex_pkg::TYPE_SEGMENT, $urandom_range(0, SEGMENT_MAX),
                             8'h00);
            else if (pick < 86)
            begin
                // end-type records that do not finish the load
                if ($urandom_range(0, 1))
                    build_record(0, $urandom_range(1, 16'hFFFF), ihex_pkg::TYPE_END,
                                 16'h0000, 8'h00);
                else
                    build_record($urandom_range(1, 8), addr, ihex_pkg::TYPE_END,
                                 16'h0000, 8'h00);
            end
            else
            begin
                kind = $urandom_range(2, 255);
                len = $urandom_range(0, MAX_DATA_BYTES);
                if (kind == ihex_pkg::TYPE_SEGMENT && len == 2)
                    len = 3;
                build_record(len, addr, kind, 16'h0000, 8'h00);
            end
            flush_line(1'b1);
        end

        // Closing case of this run
        ending = stream_end_t'($urandom_range(0, 7));
        addr = $urandom_range(0, 16'hFFFF);
        len = $urandom_range(1, MAX_DATA_BYTES);
        case (ending)
            END_OK:
            begin
                build_record(0, 16'h0000, ihex_pkg::TYPE_END, 16'h0000, 8'h00);
                flush_line(1'b1);
            end
            END_NO_COLON:
                repeat (SEARCH_LIMIT) send_char(noise_char());
            END_TRAILING:
            begin
                build_record(len, addr, ihex_pkg::TYPE_DATA, 16'h0000, 8'h00);
                flush_line(1'b0);
                c = noise_char();
                if (c == ihex_pkg::CR_CHAR)
                    c = CH_LF;
                send_char(c);
            end
            END_SHORT:
            begin
                build_record(len, addr, ihex_pkg::TYPE_DATA, 16'h0000, 8'h00);
                keep = $urandom_range(1, line_buf.size() - 1);
                while (line_buf.size() > keep)
                    line_buf.delete(line_buf.size() - 1);
                flush_line(1'b1);
            end
            END_BAD_DIGIT:
            begin
                build_record(len, addr, ihex_pkg::TYPE_DATA, 16'h0000, 8'h00);
                pos = $urandom_range(1, line_buf.size() - 1);
                do
                begin
                    c = $urandom_range(0, 255);
                    hx = hex_nibble(c);
                end
                while (hx[4]);
                line_buf[pos] = c;
                flush_line(1'b1);
            end
            END_LONG:
            begin
                build_record($urandom_range(MAX_DATA_BYTES + 1, 255), addr,
                             ihex_pkg::TYPE_DATA, 16'h0000, 8'h00);
                flush_line(1'b1);
            end
            END_SEGMENT:
            begin
                build_record(2, addr, ihex_pkg::TYPE_SEGMENT,
                             $urandom_range(SEGMENT_MAX + 1, 16'hFFFF), 8'h00);
                flush_line(1'b1);
            end
            default:
            begin
                build_record(len, addr, ihex_pkg::TYPE_DATA, 16'h0000, $urandom_range(1, 255));
                flush_line(1'b1);
            end
        endcase
        // characters after the end must be ignored with the status held
        repeat (16) send_char($urandom_range(0, 255));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(feed_done && char_results_due.size() == 0) && quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        if (quiet_cycles < QUIET_LIMIT)
            repeat (SETTLE_CYCLES) @(negedge clk);
        if (quiet_cycles < QUIET_LIMIT && mismatches == 0 && char_results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ihex_pkg.sv
rtl/ihex_decoder.sv
rtl/intel_hex_record_loader.sv
tb/testbench.sv
